[design/mktd_pkg.sv]
// ----------------------------------------------------------------------------
// mktd_pkg
// Types, codes and the letter table shared by the Morse key timing decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

  localparam int DUR_W  = 24;
  localparam int CHAR_W = 7;
  localparam int PAT_W  = 4;
  localparam int WIN_W  = 28;
  localparam int NUM_LETTERS = 26;

  localparam logic [1:0] FUNC_PRESS   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_SEND    = 2'd2;

  localparam logic [1:0] CFG_DOT_TIME  = 2'd0;
  localparam logic [1:0] CFG_DASH_TIME = 2'd1;
  localparam logic [1:0] CFG_LENIENCY  = 2'd2;

  localparam logic [DUR_W-1:0] DOT_TIME_RST  = 24'd1000000;
  localparam logic [DUR_W-1:0] DASH_TIME_RST = 24'd3000000;
  localparam logic [DUR_W-1:0] LENIENCY_RST  = 24'd500000;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'd65;

  // (length << 4) | dash bits, A to Z
  localparam logic [7:0] LETTER_CODE [NUM_LETTERS] = '{
    8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
    8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
    8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
  };

  typedef struct packed {
    logic letter_gap;
    logic word_gap;
    logic is_dot;
    logic is_dash;
  } mktd_class_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              unmatched;
    logic              end_of_message;
    logic              last;
  } mktd_result_t;

  // strictly inside (nom - len, nom + len), no wrap
  function automatic logic in_window(logic [WIN_W-1:0] d, logic [WIN_W-1:0] nom,
                                     logic [WIN_W-1:0] len);
    return ((d + len) > nom) && (d < (nom + len));
  endfunction

  // {hit, character} for a pattern of cnt symbols
  function automatic logic [CHAR_W:0] letter_of(logic [3:0] cnt, logic [PAT_W-1:0] pat);
    logic [CHAR_W:0] res;
    res = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (LETTER_CODE[i] == {cnt, pat}) begin
        res = {1'b1, CHAR_W'(CHAR_A + CHAR_W'(i))};
      end
    end
    return res;
  endfunction

endpackage

[design/mktd_classify.sv]
// ----------------------------------------------------------------------------
// mktd_classify
// Window tests of one duration against the dot, dash and gap timings.
// ----------------------------------------------------------------------------
module mktd_classify (
  input  logic [mktd_pkg::DUR_W-1:0] duration_i,
  input  logic [mktd_pkg::DUR_W-1:0] dot_time_i,
  input  logic [mktd_pkg::DUR_W-1:0] dash_time_i,
  input  logic [mktd_pkg::DUR_W-1:0] leniency_i,
  output mktd_pkg::mktd_class_t      class_o
);
  import mktd_pkg::*;

  logic [WIN_W-1:0] d, dot, dash, len, dot3, dot7;
  logic             win_dot, win_dash, win_3, win_7;

  assign d    = WIN_W'(duration_i);
  assign dot  = WIN_W'(dot_time_i);
  assign dash = WIN_W'(dash_time_i);
  assign len  = WIN_W'(leniency_i);
  assign dot3 = (dot << 1) + dot;
  assign dot7 = (dot << 3) - dot;

  assign win_dot  = in_window(d, dot, len);
  assign win_dash = in_window(d, dash, len);
  assign win_3    = in_window(d, dot3, len);
  assign win_7    = in_window(d, dot7, len);

  assign class_o.is_dot     = win_dot;
  assign class_o.is_dash    = win_dash && !win_dot;
  assign class_o.letter_gap = win_3;
  assign class_o.word_gap   = win_7 && !win_3;

endmodule

[design/mktd_decode.sv]
// ----------------------------------------------------------------------------
// mktd_decode
// Symbol pattern state, letter lookup and result generation per key event.
// ----------------------------------------------------------------------------
module mktd_decode #(
  parameter int MAX_SYMBOLS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [1:0]            func_i,
  input  mktd_pkg::mktd_class_t class_i,
  output logic [1:0]            wr_cnt_o,
  output mktd_pkg::mktd_result_t wr0_o,
  output mktd_pkg::mktd_result_t wr1_o
);
  import mktd_pkg::*;

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  logic [PAT_W-1:0] pattern_q, pattern_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             pending;
  logic [CHAR_W:0]  lookup;
  mktd_result_t     letter_res, space_res;

  assign pending = (count_q != '0) || ovf_q;
  assign lookup  = letter_of(4'(count_q), pattern_q);

  always_comb begin
    letter_res = '0;
    if (!pending) begin
      letter_res.character = CHAR_NONE;
    end else if (ovf_q || !lookup[CHAR_W]) begin
      letter_res.character = CHAR_NONE;
      letter_res.unmatched = 1'b1;
    end else begin
      letter_res.character = lookup[CHAR_W-1:0];
    end
    space_res = '0;
    space_res.character = CHAR_SPACE;
  end

  always_comb begin
    pattern_d = pattern_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    wr_cnt_o  = 2'd0;
    wr0_o     = letter_res;
    wr1_o     = space_res;
    if (valid_i) begin
      case (func_i)
        FUNC_PRESS: begin
          if (class_i.letter_gap || class_i.word_gap) begin
            pattern_d = '0;
            count_d   = '0;
            ovf_d     = 1'b0;
            if (class_i.letter_gap) begin
              wr_cnt_o = pending ? 2'd1 : 2'd0;
            end else if (pending) begin
              wr_cnt_o = 2'd2;
            end else begin
              wr_cnt_o = 2'd1;
              wr0_o    = space_res;
            end
          end
        end
        FUNC_RELEASE: begin
          if (class_i.is_dot || class_i.is_dash) begin
            if (count_q < CNT_W'(MAX_SYMBOLS)) begin
              if (class_i.is_dash && (count_q < CNT_W'(PAT_W))) begin
                pattern_d[count_q[1:0]] = 1'b1;
              end
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        FUNC_SEND: begin
          wr_cnt_o = 2'd1;
          wr0_o.end_of_message = 1'b1;
          pattern_d = '0;
          count_d   = '0;
          ovf_d     = 1'b0;
        end
        default: ;
      endcase
    end
    wr0_o.last = (wr_cnt_o == 2'd1);
    wr1_o.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      pattern_q <= pattern_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

[design/mktd_result_fifo.sv]
// ----------------------------------------------------------------------------
// mktd_result_fifo
// Four-entry result queue: up to two in, one out a cycle unless stalled.
// ----------------------------------------------------------------------------
module mktd_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             wr_cnt_i,
  input  mktd_pkg::mktd_result_t wr0_i,
  input  mktd_pkg::mktd_result_t wr1_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output mktd_pkg::mktd_result_t out_o
);
  import mktd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  mktd_result_t       mem_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PTR_W:0]     count_q, count_d;
  logic               pop;
  logic [PTR_W-1:0]   wptr_1;

  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= (PTR_W + 1)'(DEPTH - 2));
  assign wptr_1      = wptr_q + 1'b1;

  assign wptr_d  = wptr_q + PTR_W'(wr_cnt_i);
  assign rptr_d  = rptr_q + PTR_W'(pop);
  assign count_d = count_q + (PTR_W + 1)'(wr_cnt_i) - (PTR_W + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wptr_1] <= wr1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

[design/morse_key_timing_decoder.sv]
// ----------------------------------------------------------------------------
// morse_key_timing_decoder
// A key event transaction passes through the input register and then the
// result queue on its way to its first result transaction.
// Throughput: one key event per cycle while the four-entry queue holds two or
// fewer results; results leave one per cycle while the receiver does not stall.
// Reset: asynchronous, active low; clears the symbol pattern and the result
// queue and loads the nominal timings (1 s dot, 3 s dash, 0.5 s leniency).
// ----------------------------------------------------------------------------
module morse_key_timing_decoder #(
  parameter int MAX_SYMBOLS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [mktd_pkg::DUR_W-1:0]  duration_us_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mktd_pkg::CHAR_W-1:0] character_o,
  output logic                        unmatched_o,
  output logic                        end_of_message_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mktd_pkg::DUR_W-1:0]  cfg_data_i
);
  import mktd_pkg::*;

  logic [DUR_W-1:0] dot_time_q, dash_time_q, leniency_q;
  logic             in_vld_q, in_vld_d;
  logic [1:0]       func_q;
  logic [DUR_W-1:0] dur_q;
  logic             in_accept, advance, room;
  mktd_class_t      cls;
  logic [1:0]       wr_cnt;
  mktd_result_t     wr0, wr1, res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_time_q  <= DOT_TIME_RST;
      dash_time_q <= DASH_TIME_RST;
      leniency_q  <= LENIENCY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DOT_TIME:  dot_time_q  <= cfg_data_i;
        CFG_DASH_TIME: dash_time_q <= cfg_data_i;
        CFG_LENIENCY:  leniency_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      dur_q  <= duration_us_i;
    end
  end

  mktd_classify u_classify (
    .duration_i  (dur_q),
    .dot_time_i  (dot_time_q),
    .dash_time_i (dash_time_q),
    .leniency_i  (leniency_q),
    .class_o     (cls)
  );

  mktd_decode #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (advance),
    .func_i   (func_q),
    .class_i  (cls),
    .wr_cnt_o (wr_cnt),
    .wr0_o    (wr0),
    .wr1_o    (wr1)
  );

  mktd_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_cnt_i    (wr_cnt),
    .wr0_i       (wr0),
    .wr1_i       (wr1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign character_o      = res.character;
  assign unmatched_o      = res.unmatched;
  assign end_of_message_o = res.end_of_message;
  assign last_o           = res.last;

  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_message_o |-> last_o)
    else $error("end of message transaction not marked last");

  a_space_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o == CHAR_SPACE) |-> !unmatched_o && !end_of_message_o)
    else $error("space transaction carries flags");

  a_unmatched_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unmatched_o |-> (character_o == CHAR_NONE))
    else $error("unmatched transaction carries a character");

  a_no_write_without_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (wr_cnt == 2'd0))
    else $error("result written without a key event");

endmodule

[tb/morse_key_timing_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_checker
// Watches the key event, result and register write channels of the Morse key
// timing decoder, predicts the decoded characters and compares them in order.
// ----------------------------------------------------------------------------
module morse_key_timing_checker #(
  parameter int MAX_SYMBOLS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  func_i,
  input  logic [mktd_pkg::DUR_W-1:0]  duration_us_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [mktd_pkg::CHAR_W-1:0] character_i,
  input  logic                        unmatched_i,
  input  logic                        end_of_message_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mktd_pkg::DUR_W-1:0]  cfg_data_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 events_o,
  output int unsigned                 results_o,
  output int unsigned                 letters_o,
  output int unsigned                 bad_letters_o,
  output int unsigned                 spaces_o,
  output int unsigned                 ends_o
);
  import mktd_pkg::*;

  logic [DUR_W-1:0] dot_us;
  logic [DUR_W-1:0] dash_us;
  logic [DUR_W-1:0] tol_us;
  logic [PAT_W-1:0] dashes;
  logic [2:0]       held;
  logic             overflowed;
  mktd_result_t     decoded_q[$];
  int unsigned      n_err, n_events, n_results, n_letters, n_bad, n_spaces, n_ends;

  function automatic string morse_of(int k);
    case (k)
      0:  return ".-";    1:  return "-...";  2:  return "-.-.";  3:  return "-..";
      4:  return ".";     5:  return "..-.";  6:  return "--.";   7:  return "....";
      8:  return "..";    9:  return ".---";  10: return "-.-";   11: return ".-..";
      12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
      16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
      20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
      24: return "-.--";  25: return "--..";
      default: return "";
    endcase
  endfunction

  // strict window, lower edge floored at zero
  function automatic bit near_nominal(longint unsigned d, longint unsigned nom,
                                      longint unsigned tol);
    return ((nom < tol) || (d > nom - tol)) && (d < nom + tol);
  endfunction

  function automatic mktd_result_t pending_letter(logic eom);
    mktd_result_t r;
    string        code;
    int           i;
    int           k;
    r.character      = CHAR_NONE;
    r.unmatched      = 1'b0;
    r.end_of_message = eom;
    r.last           = 1'b0;
    if (held != 0 || overflowed) begin
      r.unmatched = 1'b1;
      if (!overflowed && held <= PAT_W) begin
        code = "";
        for (i = 0; i < held; i++) code = {code, dashes[i] ? "-" : "."};
        for (k = 0; k < NUM_LETTERS; k++) begin
          if (morse_of(k) == code) begin
            r.character = CHAR_A + CHAR_W'(k);
            r.unmatched = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic clear_letter();
    dashes     = '0;
    held       = '0;
    overflowed = 1'b0;
  endtask

  task automatic decode_key_event(logic [1:0] fn, logic [DUR_W-1:0] d);
    mktd_result_t    blank;
    mktd_result_t    tail;
    longint unsigned dot;
    bit              was_pending;
    bit              is_dot;
    int unsigned     size_before;
    blank.character      = CHAR_SPACE;
    blank.unmatched      = 1'b0;
    blank.end_of_message = 1'b0;
    blank.last           = 1'b0;
    dot         = dot_us;
    was_pending = (held != 0) || overflowed;
    size_before = decoded_q.size();
    case (fn)
      FUNC_PRESS: begin
        if (near_nominal(d, 3 * dot, tol_us)) begin
          if (was_pending) decoded_q.push_back(pending_letter(1'b0));
          clear_letter();
        end else if (near_nominal(d, 7 * dot, tol_us)) begin
          if (was_pending) decoded_q.push_back(pending_letter(1'b0));
          decoded_q.push_back(blank);
          clear_letter();
        end
      end
      FUNC_RELEASE: begin
        is_dot = near_nominal(d, dot, tol_us);
        if (is_dot || near_nominal(d, dash_us, tol_us)) begin
          if (held < MAX_SYMBOLS) begin
            if (!is_dot && held < PAT_W) dashes[held] = 1'b1;
            held++;
          end else begin
            overflowed = 1'b1;
          end
        end
      end
      FUNC_SEND: begin
        decoded_q.push_back(pending_letter(1'b1));
        clear_letter();
      end
      default: ;
    endcase
    if (decoded_q.size() > size_before) begin
      tail      = decoded_q.pop_back();
      tail.last = 1'b1;
      decoded_q.push_back(tail);
    end
  endtask

  task automatic compare_field(string what, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic check_result();
    mktd_result_t want;
    if (decoded_q.size() == 0) begin
      n_err++;
      $display("%0t: result with nothing outstanding, expected none, got char %0d unm %0b eom %0b last %0b",
               $time, character_i, unmatched_i, end_of_message_i, last_i);
    end else begin
      want = decoded_q.pop_front();
      n_results++;
      compare_field("character", want.character, character_i);
      compare_field("unmatched", CHAR_W'(want.unmatched), CHAR_W'(unmatched_i));
      compare_field("end_of_message", CHAR_W'(want.end_of_message), CHAR_W'(end_of_message_i));
      compare_field("last", CHAR_W'(want.last), CHAR_W'(last_i));
      if (want.character == CHAR_SPACE) n_spaces++;
      else if (want.unmatched) n_bad++;
      else if (want.character != CHAR_NONE) n_letters++;
      if (want.end_of_message) n_ends++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_us  = DOT_TIME_RST;
      dash_us = DASH_TIME_RST;
      tol_us  = LENIENCY_RST;
      clear_letter();
      decoded_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DOT_TIME:  dot_us  = cfg_data_i;
          CFG_DASH_TIME: dash_us = cfg_data_i;
          CFG_LENIENCY:  tol_us  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) begin
        n_events++;
        decode_key_event(func_i, duration_us_i);
      end
    end
    errors_o      <= n_err;
    pending_o     <= decoded_q.size();
    events_o      <= n_events;
    results_o     <= n_results;
    letters_o     <= n_letters;
    bad_letters_o <= n_bad;
    spaces_o      <= n_spaces;
    ends_o        <= n_ends;
  end

endmodule

[tb/morse_key_timing_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_test
// Drives key events and timing register writes into the Morse key timing
// decoder under random bursts and output back-pressure; the checker beside
// the block predicts every character and reports the mismatch count.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_test;
  import mktd_pkg::*;

  localparam logic [1:0]       FUNC_UNUSED  = 2'd3;
  localparam logic [DUR_W-1:0] DUR_MAX      = '1;
  localparam int unsigned      CYCLE_LIMIT  = 600000;
  localparam int unsigned      HOLD_CYCLES  = 300;
  localparam int unsigned      EVENT_TARGET = 2000;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_e;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              key_valid  = 1'b0;
  logic              key_stall;
  logic [1:0]        key_func   = FUNC_PRESS;
  logic [DUR_W-1:0]  key_dur    = '0;
  logic              res_valid;
  logic              res_stall  = 1'b0;
  logic [CHAR_W-1:0] res_char;
  logic              res_unmatched;
  logic              res_eom;
  logic              res_last;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index  = CFG_DOT_TIME;
  logic [DUR_W-1:0]  cfg_data   = '0;

  int unsigned errors, pending, events, results, letters, bad_letters, spaces, ends;

  int unsigned cur_dot, cur_dash, cur_tol;
  int unsigned burst_left   = 0;
  int unsigned events_sent  = 0;
  int unsigned settings     = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;
  bit          idle_sender  = 1'b1;
  bit          hold_req     = 1'b0;

  morse_key_timing_decoder u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (key_valid),
    .in_stall_o       (key_stall),
    .func_i           (key_func),
    .duration_us_i    (key_dur),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .character_o      (res_char),
    .unmatched_o      (res_unmatched),
    .end_of_message_o (res_eom),
    .last_o           (res_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  morse_key_timing_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (key_valid),
    .in_stall_i       (key_stall),
    .func_i           (key_func),
    .duration_us_i    (key_dur),
    .out_valid_i      (res_valid),
    .out_stall_i      (res_stall),
    .character_i      (res_char),
    .unmatched_i      (res_unmatched),
    .end_of_message_i (res_eom),
    .last_i           (res_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .errors_o         (errors),
    .pending_o        (pending),
    .events_o         (events),
    .results_o        (results),
    .letters_o        (letters),
    .bad_letters_o    (bad_letters),
    .spaces_o         (spaces),
    .ends_o           (ends)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver back-pressure
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = STALL_NONE;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  res_stall <= 1'b0;
          STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
          default:     res_stall <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  function automatic logic [DUR_W-1:0] jittered(longint unsigned nom, longint unsigned tol);
    longint unsigned lo, hi, v;
    if (tol == 0) begin
      v = nom;
    end else begin
      lo = (nom >= tol) ? nom - tol + 1 : 0;
      hi = nom + tol - 1;
      case ($urandom_range(0, 9))
        0:       v = lo;
        1:       v = hi;
        2:       v = (lo > 0) ? lo - 1 : 0;
        3:       v = hi + 1;
        default: v = lo + ($urandom % (hi - lo + 1));
      endcase
    end
    if (v > DUR_MAX) v = DUR_MAX;
    return v[DUR_W-1:0];
  endfunction

  task automatic key_event(logic [1:0] fn, logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (idle_sender) begin
        case ($urandom_range(0, 9))
          0, 1:    gap = 0;
          9:       gap = $urandom_range(10, 40);
          default: gap = $urandom_range(1, 6);
        endcase
      end
      if (gap != 0) begin
        key_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    key_valid <= 1'b1;
    key_func  <= fn;
    key_dur   <= dur;
    do @(posedge clk); while (key_stall);
    events_sent++;
  endtask

  task automatic wait_idle();
    key_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [1:0] idx, logic [DUR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic load_timing(int unsigned dot, int unsigned dash, int unsigned tol);
    cur_dot  = dot;
    cur_dash = dash;
    cur_tol  = tol;
    cfg_beat(CFG_DOT_TIME, DUR_W'(dot));
    cfg_beat(CFG_DASH_TIME, DUR_W'(dash));
    cfg_beat(CFG_LENIENCY, DUR_W'(tol));
    cfg_valid <= 1'b0;
    settings++;
    @(posedge clk);
  endtask

  task automatic send_letter();
    int unsigned n;
    int unsigned i;
    case ($urandom_range(0, 15))
      0:       n = 0;
      1, 2:    n = $urandom_range(5, 6);
      default: n = $urandom_range(1, 4);
    endcase
    for (i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 1)) key_event(FUNC_PRESS, jittered(cur_dot, cur_tol));
      if ($urandom_range(0, 1)) key_event(FUNC_RELEASE, jittered(cur_dot, cur_tol));
      else key_event(FUNC_RELEASE, jittered(cur_dash, cur_tol));
    end
    case ($urandom_range(0, 9))
      0:          key_event(FUNC_SEND, DUR_W'($urandom));
      1, 2, 3:    key_event(FUNC_PRESS, jittered(7 * longint'(cur_dot), cur_tol));
      default:    key_event(FUNC_PRESS, jittered(3 * longint'(cur_dot), cur_tol));
    endcase
  endtask

  task automatic send_noise();
    logic [DUR_W-1:0] dur;
    case ($urandom_range(0, 5))
      0:       dur = '0;
      1:       dur = DUR_MAX;
      default: dur = DUR_W'($urandom);
    endcase
    key_event(2'($urandom), dur);
  endtask

  task automatic run_phase(int unsigned n_events);
    int unsigned target;
    target = events_sent + n_events;
    while (events_sent < target) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_letter();
    end
    wait_idle();
  endtask

  initial begin
    int unsigned dot, dash, tol, i;
    cur_dot  = DOT_TIME_RST;
    cur_dash = DASH_TIME_RST;
    cur_tol  = LENIENCY_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timings: window edges, gaps, overflow, unknown pattern, send
    key_event(FUNC_RELEASE, 24'd1000000);
    key_event(FUNC_RELEASE, 24'd3000000);
    key_event(FUNC_PRESS,   24'd3000000);
    key_event(FUNC_PRESS,   24'd3000000);
    key_event(FUNC_SEND,    24'd0);
    key_event(FUNC_RELEASE, 24'd500000);
    key_event(FUNC_RELEASE, 24'd1499999);
    key_event(FUNC_RELEASE, 24'd1500000);
    key_event(FUNC_RELEASE, 24'd2500001);
    key_event(FUNC_RELEASE, 24'd3499999);
    key_event(FUNC_PRESS,   24'd7000000);
    key_event(FUNC_PRESS,   24'd7000000);
    for (i = 0; i < 5; i++) key_event(FUNC_RELEASE, 24'd1000000);
    key_event(FUNC_PRESS,   24'd2500001);
    key_event(FUNC_RELEASE, 24'd1000000);
    key_event(FUNC_RELEASE, 24'd1000000);
    key_event(FUNC_RELEASE, 24'd3000000);
    key_event(FUNC_RELEASE, 24'd3000000);
    key_event(FUNC_UNUSED,  DUR_MAX);
    key_event(FUNC_PRESS,   DUR_MAX);
    key_event(FUNC_SEND,    DUR_MAX);
    key_event(FUNC_RELEASE, 24'd3000000);
    key_event(FUNC_SEND,    24'd0);
    wait_idle();

    // long output hold-off with the sender pushing flat out
    idle_sender = 1'b0;
    hold_req    = 1'b1;
    run_phase(150);
    idle_sender = 1'b1;

    load_timing(0, 0, 0);
    run_phase(40);
    load_timing(DUR_MAX, DUR_MAX, DUR_MAX);
    run_phase(40);
    load_timing(0, DUR_MAX, 1);
    run_phase(40);
    load_timing(DUR_MAX, 0, DUR_MAX);
    run_phase(40);
    load_timing(1, 3, 1);
    run_phase(60);
    load_timing(100, 300, 150);
    run_phase(60);

    while (events_sent < EVENT_TARGET) begin
      dot = $urandom_range(1, 2000000);
      if ($urandom_range(0, 2) == 0) dash = 3 * dot;
      else dash = $urandom_range(dot, 5 * dot);
      case ($urandom_range(0, 3))
        0:       tol = dot / 2;
        1:       tol = $urandom_range(0, dot);
        2:       tol = $urandom_range(1, dot / 4 + 1);
        default: tol = $urandom_range(dot, 2 * dot);
      endcase
      idle_sender = ($urandom_range(0, 3) != 0);
      load_timing(dot, dash, tol);
      run_phase($urandom_range(100, 250));
    end

    $display("Covered %0d key events over %0d timing settings (%0d register writes),",
             events, settings, reg_writes);
    $display("checked %0d results: %0d letters, %0d unmatched, %0d spaces, %0d message ends.",
             results, letters, bad_letters, spaces, ends);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[morse_key_timing_decoder.f]
design/mktd_pkg.sv
design/mktd_classify.sv
design/mktd_decode.sv
design/mktd_result_fifo.sv
design/morse_key_timing_decoder.sv
tb/morse_key_timing_checker.sv
tb/morse_key_timing_decoder_test.sv
